/* sv/two_level_local_branch_predictor_defines.svh */
// Assertion macros for the two-level local branch predictor.
// Included by the RTL files that carry concurrent assertions.
// Assertions compile away when SYNTHESIS is defined.
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TLBP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLBP_ASSERT(lbl, clk, rst_n, prop)
`define TLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/tlbp_pkg.sv */
// Package for the two-level local branch predictor: sizes, table entry
// type and allocation constants. No dependencies.
`timescale 1ns / 1ps

package tlbp_pkg;

  localparam int INDEX_BITS    = 10;
  localparam int ADDR_BITS     = 32;
  localparam int HISTORY_BITS  = 2;
  localparam int BRANCH_ADDR_W = 32;
  localparam int COUNT_W       = 32;

  localparam int TAG_BITS    = ADDR_BITS - INDEX_BITS;
  localparam int PATTERN_W   = 1 << HISTORY_BITS;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;

  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic [TAG_BITS-1:0]     tag_t;
  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef logic [PATTERN_W-1:0]    pattern_t;
  typedef logic [COUNT_W-1:0]      count_t;

  // pattern i = i mod 2 on allocation, all parity bits set, history all ones
  localparam pattern_t PATTERN_INIT = pattern_t'({(PATTERN_W / 2){2'b10}});
  localparam pattern_t PARITY_INIT  = '1;
  localparam hist_t    HIST_INIT    = '1;
  localparam count_t   COUNT_MAX    = '1;

  typedef struct packed {
    logic     valid;
    tag_t     tag;
    hist_t    history;
    pattern_t pattern;
    pattern_t parity;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic predicted_taken;
    logic table_hit;
    logic prediction_correct;
  } verdict_t;

endpackage

/* sv/tlbp_if.sv */
// Valid/ready channels of the branch predictor: resolved branches in,
// predictions and counts out. Depends on tlbp_pkg.
`timescale 1ns / 1ps

interface tlbp_branch_if;
  import tlbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BRANCH_ADDR_W-1:0] branch_address;
  logic                     branch_taken;

  modport source (output valid, output branch_address, output branch_taken, input ready);
  modport sink   (input valid, input branch_address, input branch_taken, output ready);
endinterface

interface tlbp_result_if;
  import tlbp_pkg::*;

  logic               valid;
  logic               ready;
  logic               predicted_taken;
  logic               table_hit;
  logic               prediction_correct;
  logic [COUNT_W-1:0] correct_count;
  logic [COUNT_W-1:0] branches_seen;

  modport source (output valid, output predicted_taken, output table_hit,
                  output prediction_correct, output correct_count,
                  output branches_seen, input ready);
  modport sink   (input valid, input predicted_taken, input table_hit,
                  input prediction_correct, input correct_count,
                  input branches_seen, output ready);
endinterface

/* sv/tlbp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tlbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tlbp_entry_update.sv */
// Per-branch predict and update of one table entry: tag check,
// allocation, pattern lookup, miss-parity flip and history shift.
// Depends on tlbp_pkg.
`timescale 1ns / 1ps

module tlbp_entry_update (
  input  tlbp_pkg::entry_t   entry_i,
  input  tlbp_pkg::tag_t     tag_i,
  input  logic               taken_i,
  output tlbp_pkg::entry_t   entry_o,
  output tlbp_pkg::verdict_t verdict_o
);
  import tlbp_pkg::*;

  logic     hit;
  logic     pred;
  hist_t    h;
  pattern_t pat;
  pattern_t par;

  always_comb begin
    hit = entry_i.valid && (entry_i.tag == tag_i);
    if (hit) begin
      h    = entry_i.history;
      pat  = entry_i.pattern;
      par  = entry_i.parity;
      pred = pat[h];
      if (pred == taken_i) begin
        par[h] = 1'b0;
      end else begin
        par[h] = ~par[h];
        // pattern bit flips on every second consecutive miss
        if (!par[h]) begin
          pat[h] = ~pat[h];
        end
      end
    end else begin
      h      = HIST_INIT;
      pat    = PATTERN_INIT;
      par    = PARITY_INIT;
      pred   = 1'b1;
      par[h] = 1'b0;
      if (!taken_i) begin
        pat[h] = 1'b0;
      end
    end

    entry_o.valid   = 1'b1;
    entry_o.tag     = tag_i;
    entry_o.history = {h[HISTORY_BITS-2:0], taken_i};
    entry_o.pattern = pat;
    entry_o.parity  = par;

    verdict_o.predicted_taken    = pred;
    verdict_o.table_hit          = hit;
    verdict_o.prediction_correct = (pred == taken_i);
  end

endmodule

/* sv/two_level_local_branch_predictor.sv */
// Two-level local-history branch predictor: one resolved branch in,
// prediction, hit and correctness flags and running counts out. Depends on
// tlbp_pkg, tlbp_if, tlbp_ram, tlbp_entry_update and the defines header.
//
// One branch per clock, sustained while the result side is ready; a branch
// passes through the lookup stage and the output register. The table RAM
// has registered read data: the entry is read at acceptance, updated in the
// lookup stage and written back, with a one-entry bypass covering a
// back-to-back access to the same index. Both running counts saturate at
// all ones. After reset all 2^INDEX_BITS entries (1024 as built) are swept
// clear one a cycle; branch_i.ready stays low until the sweep has finished.
`timescale 1ns / 1ps

`include "two_level_local_branch_predictor_defines.svh"

module two_level_local_branch_predictor (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlbp_branch_if.sink   branch_i,
  tlbp_result_if.source result_o
);
  import tlbp_pkg::*;

  // clearing sweep
  logic   clearing_q;
  index_t clr_q;

  // lookup stage
  logic   s1_valid_q;
  index_t s1_idx_q;
  tag_t   s1_tag_q;
  logic   s1_taken_q;

  // bypass of the write made in the cycle the current lookup was issued
  logic   byp_valid_q;
  index_t byp_idx_q;
  entry_t byp_entry_q;

  // result register and counters
  logic   out_valid_q;
  logic   out_pred_q;
  logic   out_hit_q;
  logic   out_ok_q;
  count_t out_correct_q;
  count_t out_seen_q;
  count_t correct_total_q, correct_total_d;
  count_t branch_total_q, branch_total_d;

  logic     accept;
  logic     advance;
  addr_t    in_addr;
  entry_t   rd_entry;
  entry_t   cur_entry;
  entry_t   new_entry;
  verdict_t verdict;

  logic   ram_we;
  index_t ram_waddr;
  entry_t ram_wdata;

  assign in_addr = addr_t'(branch_i.branch_address);
  assign advance = s1_valid_q && (!out_valid_q || result_o.ready);
  assign branch_i.ready = !clearing_q && (!s1_valid_q || advance);
  assign accept  = branch_i.valid && branch_i.ready;

  assign ram_we    = clearing_q || advance;
  assign ram_waddr = clearing_q ? clr_q : s1_idx_q;
  assign ram_wdata = clearing_q ? entry_t'('0) : new_entry;

  tlbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr[INDEX_BITS-1:0]),
    .rdata_o (rd_entry)
  );

  assign cur_entry = (byp_valid_q && (byp_idx_q == s1_idx_q)) ? byp_entry_q : rd_entry;

  tlbp_entry_update u_update (
    .entry_i   (cur_entry),
    .tag_i     (s1_tag_q),
    .taken_i   (s1_taken_q),
    .entry_o   (new_entry),
    .verdict_o (verdict)
  );

  always_comb begin
    correct_total_d = correct_total_q;
    if (verdict.prediction_correct && (correct_total_q != COUNT_MAX)) begin
      correct_total_d = correct_total_q + 1'b1;
    end
    branch_total_d = branch_total_q;
    if (branch_total_q != COUNT_MAX) begin
      branch_total_d = branch_total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q      <= 1'b1;
      clr_q           <= '0;
      s1_valid_q      <= 1'b0;
      byp_valid_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      correct_total_q <= '0;
      branch_total_q  <= '0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q  <= 1'b1;
        byp_valid_q <= advance;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q     <= 1'b1;
        correct_total_q <= correct_total_d;
        branch_total_q  <= branch_total_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q    <= in_addr[INDEX_BITS-1:0];
      s1_tag_q    <= in_addr[ADDR_BITS-1:INDEX_BITS];
      s1_taken_q  <= branch_i.branch_taken;
      byp_idx_q   <= s1_idx_q;
      byp_entry_q <= new_entry;
    end
    if (advance) begin
      out_pred_q    <= verdict.predicted_taken;
      out_hit_q     <= verdict.table_hit;
      out_ok_q      <= verdict.prediction_correct;
      out_correct_q <= correct_total_d;
      out_seen_q    <= branch_total_d;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.predicted_taken    = out_pred_q;
  assign result_o.table_hit          = out_hit_q;
  assign result_o.prediction_correct = out_ok_q;
  assign result_o.correct_count      = out_correct_q;
  assign result_o.branches_seen      = out_seen_q;

  `TLBP_ASSERT(a_no_accept_while_clearing, clk_i, rst_ni, clearing_q |-> !branch_i.ready)
  `TLBP_ASSERT(a_correct_within_total, clk_i, rst_ni, correct_total_q <= branch_total_q)
  `TLBP_ASSERT(a_alloc_predicts_taken, clk_i, rst_ni, (out_valid_q && !out_hit_q) |-> out_pred_q)
  `TLBP_ASSERT_NEXT(a_total_steps, clk_i, rst_ni, advance && (branch_total_q != COUNT_MAX), branch_total_q == $past(branch_total_q) + 1'b1)

endmodule

/* dv/tlbp_prediction_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the two-level local branch predictor: mirrors the branch
// table, predicts each result item and checks it. Depends on tlbp_pkg, tlbp_if.

module tlbp_prediction_checker
  import tlbp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tlbp_branch_if branch_mon,
  tlbp_result_if result_mon,
  output int     fail_count_o,
  output int     pending_o
);

  // patterns 0,1,0,1 on allocation
  localparam pattern_t ALLOC_PATTERN = pattern_t'(4'b1010);
  localparam pattern_t ALLOC_PARITY  = pattern_t'(4'b1111);
  localparam hist_t    ALLOC_HIST    = hist_t'(2'b11);
  localparam count_t   COUNT_SAT     = '1;
  localparam int       REPORT_LIMIT  = 10;

  typedef struct packed {
    logic   predicted_taken;
    logic   table_hit;
    logic   prediction_correct;
    count_t correct_count;
    count_t branches_seen;
  } branch_outcome_t;

  logic     tbl_valid   [TABLE_DEPTH];
  tag_t     tbl_tag     [TABLE_DEPTH];
  hist_t    tbl_hist    [TABLE_DEPTH];
  pattern_t tbl_pattern [TABLE_DEPTH];
  pattern_t tbl_parity  [TABLE_DEPTH];
  count_t   correct_total;
  count_t   branch_total;

  branch_outcome_t expected_outcomes[$];
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic branch_outcome_t predict_branch(input logic [BRANCH_ADDR_W-1:0] raw_addr,
                                                     input logic taken);
    addr_t           addr;
    index_t          idx;
    tag_t            tg;
    hist_t           h;
    branch_outcome_t res;
    addr = raw_addr[ADDR_BITS-1:0];
    idx  = addr[INDEX_BITS-1:0];
    tg   = addr[ADDR_BITS-1:INDEX_BITS];
    if (tbl_valid[idx] && tbl_tag[idx] == tg) begin
      res.table_hit       = 1'b1;
      h                   = tbl_hist[idx];
      res.predicted_taken = tbl_pattern[idx][h];
      if (res.predicted_taken == taken) begin
        tbl_parity[idx][h] = 1'b0;
      end else begin
        // second consecutive miss on this history flips the pattern bit
        tbl_parity[idx][h] = ~tbl_parity[idx][h];
        if (!tbl_parity[idx][h]) tbl_pattern[idx][h] = ~tbl_pattern[idx][h];
      end
    end else begin
      res.table_hit       = 1'b0;
      res.predicted_taken = 1'b1;
      tbl_valid[idx]      = 1'b1;
      tbl_tag[idx]        = tg;
      tbl_pattern[idx]    = ALLOC_PATTERN;
      tbl_parity[idx]     = ALLOC_PARITY;
      h                   = ALLOC_HIST;
      tbl_parity[idx][h]  = 1'b0;
      if (!taken) tbl_pattern[idx][h] = 1'b0;
    end
    tbl_hist[idx] = {h[HISTORY_BITS-2:0], taken};
    res.prediction_correct = (res.predicted_taken == taken);
    if (res.prediction_correct && correct_total != COUNT_SAT) correct_total++;
    if (branch_total != COUNT_SAT) branch_total++;
    res.correct_count = correct_total;
    res.branches_seen = branch_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    branch_outcome_t got;
    branch_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      correct_total = '0;
      branch_total  = '0;
      expected_outcomes.delete();
      pending_o <= 0;
    end else begin
      // retire before predicting: a result never belongs to a same-edge branch
      if (result_mon.valid && result_mon.ready) begin
        got.predicted_taken    = result_mon.predicted_taken;
        got.table_hit          = result_mon.table_hit;
        got.prediction_correct = result_mon.prediction_correct;
        got.correct_count      = result_mon.correct_count;
        got.branches_seen      = result_mon.branches_seen;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result item: pred %0b hit %0b ok %0b correct %0d seen %0d",
                     $realtime, got.predicted_taken, got.table_hit, got.prediction_correct,
                     got.correct_count, got.branches_seen);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch (expected / actual)", $realtime);
              $display("  predicted_taken    %0b / %0b", want.predicted_taken,
                       got.predicted_taken);
              $display("  table_hit          %0b / %0b", want.table_hit, got.table_hit);
              $display("  prediction_correct %0b / %0b", want.prediction_correct,
                       got.prediction_correct);
              $display("  correct_count      %0d / %0d", want.correct_count,
                       got.correct_count);
              $display("  branches_seen      %0d / %0d", want.branches_seen,
                       got.branches_seen);
            end
          end
        end
      end
      if (branch_mon.valid && branch_mon.ready)
        expected_outcomes.push_back(predict_branch(branch_mon.branch_address,
                                                   branch_mon.branch_taken));
      pending_o <= expected_outcomes.size();
    end
  end

endmodule

/* dv/tb_two_level_local_branch_predictor.sv */
`timescale 1ns / 1ps
// Top of the branch predictor testbench: clock, reset, branch stimulus and
// result back-pressure. Depends on tlbp_pkg, tlbp_if and the checker.

module tb_two_level_local_branch_predictor;
  import tlbp_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 6;
  localparam int PHASE_ITEMS      = 370;
  localparam int SITE_COUNT       = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200000;

  typedef enum int {
    SITE_ALWAYS, SITE_NEVER, SITE_LOOP, SITE_ALTERNATE, SITE_BIASED, SITE_COIN
  } site_kind_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;

  // branch sites of the current phase: each replays its own outcome pattern
  logic [BRANCH_ADDR_W-1:0] site_addr   [SITE_COUNT];
  site_kind_e               site_kind   [SITE_COUNT];
  int                       site_period [SITE_COUNT];
  int                       site_step   [SITE_COUNT];

  tlbp_branch_if branch_ch ();
  tlbp_result_if result_ch ();

  two_level_local_branch_predictor u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .branch_i (branch_ch),
    .result_o (result_ch)
  );

  tlbp_prediction_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .branch_mon   (branch_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_branch(input logic [BRANCH_ADDR_W-1:0] addr, input logic taken);
    while ($urandom_range(99) < send_idle_pct) begin
      branch_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    branch_ch.valid          <= 1'b1;
    branch_ch.branch_address <= addr;
    branch_ch.branch_taken   <= taken;
    @(posedge clk_i);
    while (!branch_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    branch_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic site_outcome(input int s);
    logic t;
    case (site_kind[s])
      SITE_ALWAYS:    t = 1'b1;
      SITE_NEVER:     t = 1'b0;
      SITE_LOOP:      t = ((site_step[s] % site_period[s]) != site_period[s] - 1);
      SITE_ALTERNATE: t = site_step[s][0];
      SITE_BIASED:    t = ($urandom_range(9) != 0);
      default:        t = logic'($urandom_range(1));
    endcase
    site_step[s]++;
    return t;
  endfunction

  task automatic build_sites();
    logic [BRANCH_ADDR_W-1:0] a;
    for (int i = 0; i < SITE_COUNT; i++) begin
      a = $urandom();
      // some sites alias an earlier one's index with another tag
      if (i > 0 && $urandom_range(3) == 0)
        a[INDEX_BITS-1:0] = site_addr[$urandom_range(i - 1)][INDEX_BITS-1:0];
      site_addr[i]   = a;
      site_kind[i]   = site_kind_e'($urandom_range(SITE_COIN));
      site_period[i] = $urandom_range(2, 6);
      site_step[i]   = 0;
    end
  endtask

  task automatic random_branch();
    int                       roll;
    int                       pick;
    logic [BRANCH_ADDR_W-1:0] a;
    logic                     t;
    roll = $urandom_range(99);
    pick = $urandom_range(SITE_COUNT - 1);
    if (roll < 10) begin
      a = $urandom();
      t = logic'($urandom_range(1));
    end else begin
      a = site_addr[pick];
      t = (roll < 15) ? logic'($urandom_range(1)) : site_outcome(pick);
    end
    send_branch(a, t);
  endtask

  task automatic run_directed();
    // allocate taken, then hit paths on one entry, including a pattern flip
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b0);
    // allocate not taken at the top address
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    // same index, other tag: evict and re-allocate
    send_branch(32'h0000_0400, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_03FF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    // alternating outcome misses on two histories until both pattern bits flip
    for (int i = 0; i < 8; i++) send_branch(32'h1234_5678, logic'(i % 2));
    send_branch(32'hFFFF_FC00, 1'b0);
    send_branch(32'h0000_03FF, 1'b0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int items,
                           input bit long_hold, input bit drain_pause);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    build_sites();
    for (int n = 0; n < items; n++) begin
      if (long_hold && n == items / 4) hold_req = 1'b1;
      if (drain_pause && n == items / 2) wait_drained();
      random_branch();
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    branch_ch.valid          = 1'b0;
    branch_ch.branch_address = '0;
    branch_ch.branch_taken   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_phase(0, 0, PHASE_ITEMS, 1'b1, 1'b0);
    run_phase(65, 0, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(0, 65, PHASE_ITEMS, 1'b0, 1'b1);
    run_phase(7, 7, PHASE_ITEMS, 1'b0, 1'b0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
